// ===== rtl/prc_pkg.sv =====
// Package for the PIN retry counter table: codes, widths and tally helpers.
// No dependencies; compiled first, imported by the interfaces and the top level.
package prc_pkg;

    localparam int NUM_REFS  = 4;
    localparam int IDX_W     = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
    localparam int TALLY_W   = 8;
    localparam int CNT_W     = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        REQ_SET     = 2'd0,
        REQ_VERIFY  = 2'd1,
        REQ_UNBLOCK = 2'd2,
        REQ_GET     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PARAM   = 3'd1,
        ST_UNSET   = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_WRONG   = 3'd4,
        ST_ENTROPY = 3'd5,
        ST_CORRUPT = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REC_UNSET   = 2'd0,
        REC_ACTIVE  = 2'd1,
        REC_BLOCKED = 2'd2
    } t_rec;

    typedef enum logic [1:0] {
        CFG_MAX_TRY = 2'd0,
        CFG_MIN_LEN = 2'd1,
        CFG_MAX_LEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_req       req_type;
        logic [3:0] pin_ref;
        logic [7:0] pin_length;
        logic [7:0] new_try_limit;
        logic       pin_matches;
        logic       entropy_ok;
    } t_req_item;

    // Unary tally with the low 'limit' bits set, saturating at a full byte.
    function automatic logic [TALLY_W-1:0] full_tally(input logic [CNT_W-1:0] limit);
        logic [TALLY_W:0] ones;
        if (limit >= CNT_W'(TALLY_W)) begin
            return '1;
        end
        ones = ((TALLY_W+1)'(1) << limit) - (TALLY_W+1)'(1);
        return ones[TALLY_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] popcount8(input logic [TALLY_W-1:0] t);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < TALLY_W; i++) begin
            n = n + CNT_W'(t[i]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/prc_if.sv =====
// Valid/ready channel interfaces for the PIN retry counter table.
// Depends on prc_pkg for the request, status and record codes.
interface prc_req_if import prc_pkg::*;;
    logic       valid;
    logic       ready;
    t_req       req_type;
    logic [3:0] pin_ref;
    logic [7:0] pin_length;
    logic [7:0] new_try_limit;
    logic       pin_matches;
    logic       entropy_ok;

    modport source (output valid, req_type, pin_ref, pin_length, new_try_limit,
                    pin_matches, entropy_ok, input ready);
    modport sink   (input valid, req_type, pin_ref, pin_length, new_try_limit,
                    pin_matches, entropy_ok, output ready);
endinterface

interface prc_rsp_if import prc_pkg::*;;
    logic       valid;
    logic       ready;
    t_status    status;
    t_rec       record_state;
    logic [3:0] record_try_limit;
    logic [3:0] tries_remaining;

    modport source (output valid, status, record_state, record_try_limit, tries_remaining,
                    input ready);
    modport sink   (input valid, status, record_state, record_try_limit, tries_remaining,
                    output ready);
endinterface

// ===== rtl/pin_retry_counter_table.sv =====
// PIN retry counter table: top level with the record table and the APB registers.
// Depends on prc_pkg and on the channel interfaces in prc_if.sv.
//
// Usage:
//  - i_req carries one request per transfer (set, verify, unblock, get). o_rsp
//    returns exactly one result per request, in request order.
//  - A request is captured in an input register; once the result register is
//    empty or being taken, it reads the addressed record, updates it and
//    loads the result register, which drives o_rsp.
//  - Throughput is one request per cycle: the input register drains into the
//    result register whenever that register is empty or being taken, so a
//    new request can follow every cycle while o_rsp.ready stays high.
//  - When the receiver stalls, the result register holds and the input
//    register holds one more request; after that i_req.ready drops.
//  - Back-to-back requests on the same reference see each other's updates:
//    the table is written at the same edge that loads the result register.
//  - APB: registers max_try_limit (0x0), min_pin_length (0x4) and
//    max_pin_length (0x8); write them only while no request is in flight.
//    pready is tied high; reads return the register value.
//  - Reset (synchronous, active low) empties both registers, marks every
//    record unset with zero limit and tally, and loads the register
//    defaults 8, 4 and 16.
module pin_retry_counter_table import prc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    prc_req_if.sink            i_req,
    prc_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // configuration
    logic [3:0] r_max_try;
    logic [5:0] r_min_len;
    logic [5:0] r_max_len;

    // record table, one entry per reference 1..NUM_REFS
    t_rec             r_state [NUM_REFS];
    logic [CNT_W-1:0] r_limit [NUM_REFS];
    logic [TALLY_W-1:0] r_tally [NUM_REFS];

    // input register
    logic      r_in_valid;
    t_req_item r_in;

    // result register
    logic       r_out_valid;
    t_status    r_status;
    t_rec       r_rec_state;
    logic [3:0] r_rec_limit;
    logic [3:0] r_tries;

    logic       advance;
    logic       cfg_wr;
    t_cfg_idx   cfg_idx;

    logic             ref_ok;
    logic [IDX_W-1:0] k;
    t_rec             cur_state;
    logic [CNT_W-1:0] cur_limit;
    logic [TALLY_W-1:0] cur_tally;
    logic [TALLY_W-1:0] spent;
    logic [CNT_W-1:0] eff_max;
    logic             write_rec;
    t_status          n_status;
    t_rec             n_state;
    logic [CNT_W-1:0] n_limit;
    logic [TALLY_W-1:0] n_tally;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.record_state     = r_rec_state;
    assign o_rsp.record_try_limit = r_rec_limit;
    assign o_rsp.tries_remaining  = r_tries;

    // APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            CFG_MAX_TRY: prdata = PDATA_W'(r_max_try);
            CFG_MIN_LEN: prdata = PDATA_W'(r_min_len);
            CFG_MAX_LEN: prdata = PDATA_W'(r_max_len);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_try <= 4'd8;
            r_min_len <= 6'd4;
            r_max_len <= 6'd16;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_MAX_TRY: r_max_try <= pwdata[3:0];
                CFG_MIN_LEN: r_min_len <= pwdata[5:0];
                CFG_MAX_LEN: r_max_len <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Record lookup and update
    assign ref_ok    = (r_in.pin_ref != 4'd0) && (r_in.pin_ref <= 4'(NUM_REFS));
    assign k         = IDX_W'(r_in.pin_ref - 4'd1);
    assign cur_state = r_state[k];
    assign cur_limit = r_limit[k];
    assign cur_tally = r_tally[k];
    assign spent     = cur_tally & (cur_tally - TALLY_W'(1));
    // a tally holds at most eight tries
    assign eff_max   = (r_max_try > CNT_W'(TALLY_W)) ? CNT_W'(TALLY_W) : r_max_try;

    always_comb begin
        n_status  = ST_OK;
        n_state   = cur_state;
        n_limit   = cur_limit;
        n_tally   = cur_tally;
        write_rec = 1'b0;
        unique case (r_in.req_type)
            REQ_SET: begin
                if ((r_in.pin_length < 8'(r_min_len)) || (r_in.pin_length > 8'(r_max_len))
                    || (r_in.new_try_limit == 8'd0)
                    || (r_in.new_try_limit > 8'(eff_max))) begin
                    n_status = ST_PARAM;
                end else if (!r_in.entropy_ok) begin
                    n_status = ST_ENTROPY;
                end else begin
                    write_rec = 1'b1;
                    n_state   = REC_ACTIVE;
                    n_limit   = r_in.new_try_limit[CNT_W-1:0];
                    n_tally   = full_tally(r_in.new_try_limit[CNT_W-1:0]);
                end
            end
            REQ_VERIFY: begin
                if (cur_state == REC_UNSET) begin
                    n_status = ST_UNSET;
                end else if (cur_state == REC_BLOCKED) begin
                    n_status = ST_BLOCKED;
                end else if (cur_tally == '0) begin
                    write_rec = 1'b1;
                    n_state   = REC_BLOCKED;
                    n_status  = ST_BLOCKED;
                end else begin
                    write_rec = 1'b1;
                    if (r_in.pin_matches) begin
                        n_tally = full_tally(cur_limit);
                    end else if (spent == '0) begin
                        n_tally  = spent;
                        n_state  = REC_BLOCKED;
                        n_status = ST_BLOCKED;
                    end else begin
                        n_tally  = spent;
                        n_status = ST_WRONG;
                    end
                end
            end
            REQ_UNBLOCK: begin
                if (cur_state == REC_UNSET) begin
                    n_status = ST_UNSET;
                end else if ((cur_limit == '0) || (cur_limit > eff_max)) begin
                    n_status = ST_CORRUPT;
                end else begin
                    write_rec = 1'b1;
                    n_state   = REC_ACTIVE;
                    n_tally   = full_tally(cur_limit);
                end
            end
            default: ;  // get: report only
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REFS; i++) begin
                r_state[i] <= REC_UNSET;
                r_limit[i] <= '0;
                r_tally[i] <= '0;
            end
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && ref_ok && write_rec) begin
                r_state[k] <= n_state;
                r_limit[k] <= n_limit;
                r_tally[k] <= n_tally;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.req_type      <= i_req.req_type;
            r_in.pin_ref       <= i_req.pin_ref;
            r_in.pin_length    <= i_req.pin_length;
            r_in.new_try_limit <= i_req.new_try_limit;
            r_in.pin_matches   <= i_req.pin_matches;
            r_in.entropy_ok    <= i_req.entropy_ok;
        end
        if (advance) begin
            if (ref_ok) begin
                r_status    <= n_status;
                r_rec_state <= n_state;
                r_rec_limit <= n_limit;
                r_tries     <= popcount8(n_tally);
            end else begin
                // unknown reference: param, record fields zero
                r_status    <= ST_PARAM;
                r_rec_state <= REC_UNSET;
                r_rec_limit <= '0;
                r_tries     <= '0;
            end
        end
    end

endmodule
